// File: rtl/core/lpsc_pkg.sv
// Shared types and constants for the length-prefix to start-code converter.
`timescale 1ns / 1ps
`default_nettype none

package lpsc_pkg;

	// Configuration: prefix size in bytes after reset
	localparam logic [2:0] PREFIX_BYTES_RST = 3'd4;
	localparam logic [2:0] PREFIX_MIN       = 3'd1;
	localparam logic [2:0] PREFIX_MAX       = 3'd4;

	// Default depth of the command queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Final start code byte; the three before it are zero
	localparam logic [7:0] START_CODE_LAST = 8'h01;
	localparam logic [1:0] START_CODE_END  = 2'd3;

	// What the back end has to do for one accepted input byte
	typedef enum logic [1:0] {
		KIND_START   = 2'd0, // emit 00 00 00 01
		KIND_PAYLOAD = 2'd1, // copy one payload byte
		KIND_STATUS  = 2'd2  // status-only truncation marker
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       sample_end;
		logic       truncated;
	} q_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/lpsc_front.sv
// Front end: prefix gathering, payload counting and command classification.
`timescale 1ns / 1ps
`default_nettype none

module lpsc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_wdata,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,
	input  wire logic               s_tlast,
	input  wire logic               q_full,
	output logic                    q_push,
	output lpsc_pkg::q_entry_t      q_entry
);
	import lpsc_pkg::*;

	logic [2:0]  prefix_bytes_q;
	logic        in_payload_q;
	logic [1:0]  prefix_count_q;
	logic [31:0] length_accum_q;
	logic [31:0] payload_left_q;

	logic        accept;
	logic [2:0]  eff_prefix;
	logic [31:0] len_next;
	logic        prefix_done;
	logic        payload_done;

	assign s_tready = ~q_full;
	assign accept   = s_tvalid & s_tready;

	// Clamp the prefix size to one to four bytes
	always_comb begin
		eff_prefix = prefix_bytes_q;
		if (prefix_bytes_q < PREFIX_MIN) eff_prefix = PREFIX_MIN;
		if (prefix_bytes_q > PREFIX_MAX) eff_prefix = PREFIX_MAX;
	end

	assign len_next     = {length_accum_q[23:0], s_tdata};
	assign prefix_done  = ({1'b0, prefix_count_q} + 3'd1) >= eff_prefix;
	// last payload byte: the count would hit zero after this one
	assign payload_done = payload_left_q == 32'd1;

	// Classify the byte into a command for the back end
	always_comb begin
		q_push             = 1'b0;
		q_entry.kind       = KIND_PAYLOAD;
		q_entry.data       = s_tdata;
		q_entry.sample_end = s_tlast;
		q_entry.truncated  = 1'b0;
		if (in_payload_q) begin
			q_push            = accept;
			q_entry.truncated = s_tlast & ~payload_done;
		end else if (prefix_done) begin
			q_push            = accept;
			q_entry.kind      = KIND_START;
			q_entry.truncated = s_tlast & (len_next != 32'd0);
		end else if (s_tlast) begin
			q_push            = accept;
			q_entry.kind      = KIND_STATUS;
			q_entry.truncated = 1'b1;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_bytes_q <= PREFIX_BYTES_RST;
		end else if (cfg_we) begin
			prefix_bytes_q <= cfg_wdata;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q   <= 1'b0;
			prefix_count_q <= '0;
			length_accum_q <= '0;
			payload_left_q <= '0;
		end else if (accept) begin
			if (in_payload_q) begin
				if (payload_done || s_tlast) begin
					in_payload_q   <= 1'b0;
					payload_left_q <= '0;
				end else begin
					payload_left_q <= payload_left_q - 32'd1;
				end
			end else if (prefix_done) begin
				prefix_count_q <= '0;
				length_accum_q <= '0;
				if ((len_next != 32'd0) && !s_tlast) begin
					in_payload_q   <= 1'b1;
					payload_left_q <= len_next;
				end
			end else if (s_tlast) begin
				prefix_count_q <= '0;
				length_accum_q <= '0;
			end else begin
				prefix_count_q <= prefix_count_q + 2'd1;
				length_accum_q <= len_next;
			end
		end
	end

	// A payload run always has bytes left to count
	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (payload_left_q != 32'd0))
		else $error("payload state with zero count");

	// Prefix gathering leaves no stale length behind on entry to payload
	a_payload_entry_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_payload_q) |-> (prefix_count_q == 2'd0) && (length_accum_q == 32'd0))
		else $error("prefix state not cleared on payload entry");

endmodule

`default_nettype wire

// File: rtl/core/lpsc_queue.sv
// Short command queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module lpsc_queue #(
	parameter int DEPTH = lpsc_pkg::QUEUE_DEPTH_DEF // 2 or more
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire lpsc_pkg::q_entry_t wr_entry,
	output logic                    full,
	input  wire logic               pop,
	output logic                    empty,
	output lpsc_pkg::q_entry_t      rd_entry
);
	import lpsc_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign rd_entry = mem_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: rtl/core/lpsc_back.sv
// Back end: expands queued commands into output transfers.
`timescale 1ns / 1ps
`default_nettype none

module lpsc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire lpsc_pkg::q_entry_t q_entry,
	output logic                    q_pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,
	output logic                    m_tlast,
	output logic [2:0]              m_tuser
);
	import lpsc_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_bv_q;
	logic       out_last_q;
	logic       out_se_q;
	logic       out_tr_q;
	logic [1:0] sc_idx_q;

	logic       load;
	logic       take;
	logic [7:0] nx_byte;
	logic       nx_bv;
	logic       nx_last;
	logic       nx_se;
	logic       nx_tr;
	logic       sc_end;

	assign load   = ~out_valid_q | m_tready;
	assign take   = load & ~q_empty;
	assign sc_end = sc_idx_q == START_CODE_END;

	// Next output transfer from the head command
	always_comb begin
		nx_byte = 8'd0;
		nx_bv   = 1'b1;
		nx_last = 1'b1;
		nx_se   = q_entry.sample_end;
		nx_tr   = q_entry.truncated;
		q_pop   = take;
		unique case (q_entry.kind)
			KIND_START: begin
				nx_byte = sc_end ? START_CODE_LAST : 8'd0;
				nx_last = sc_end;
				nx_se   = sc_end & q_entry.sample_end;
				nx_tr   = sc_end & q_entry.truncated;
				q_pop   = take & sc_end;
			end
			KIND_PAYLOAD: begin
				nx_byte = q_entry.data;
			end
			KIND_STATUS: begin
				nx_bv = 1'b0;
			end
			default: begin
				nx_bv = 1'b0;
			end
		endcase
	end

	// Output register and start code position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sc_idx_q    <= '0;
		end else if (load) begin
			out_valid_q <= ~q_empty;
			if (take && (q_entry.kind == KIND_START))
				sc_idx_q <= sc_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= nx_byte;
			out_bv_q   <= nx_bv;
			out_last_q <= nx_last;
			out_se_q   <= nx_se;
			out_tr_q   <= nx_tr;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_tr_q, out_se_q, out_bv_q};

	// Mid start code the head command must still be that start code
	a_sc_head: assert property (@(posedge clk) disable iff (!arst_n)
		(sc_idx_q != 2'd0) |-> !q_empty && (q_entry.kind == KIND_START))
		else $error("start code interrupted");

	// Sample end and truncation only on the final transfer of a byte
	a_flags_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_se_q || out_tr_q) |-> out_last_q && out_se_q)
		else $error("sample flags off the final transfer");

endmodule

`default_nettype wire

// File: rtl/core/length_prefix_to_start_code.sv
// Top level: length-prefixed sample bytes in, start-code delimited bytes out.
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  tdata = in_byte, tlast = sample_last
//  m_*      out  m_tvalid/m_tready  tdata = out_byte, tlast = run_last,
//                                   tuser = byte_valid, sample_end, truncated
//  cfg_*    in   cfg_we             cfg_wdata = prefix_bytes
//
// Input bytes are taken while the queue is not full. A payload byte gives one
// output transfer and a completed prefix gives four; the back end's single output
// register sends one transfer a cycle while m_tready is high. The queue of
// QUEUE_DEPTH commands lets input run ahead of a start code or an output stall.
// Reset clears all control state and sets prefix_bytes to 4; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module length_prefix_to_start_code #(
	parameter int QUEUE_DEPTH = lpsc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tlast,
	output logic [2:0]      m_tuser    // [0] byte_valid, [1] sample_end, [2] truncated
);
	import lpsc_pkg::*;

	q_entry_t wr_entry;
	q_entry_t rd_entry;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;

	lpsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (wr_entry)
	);

	lpsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.rd_entry (rd_entry)
	);

	lpsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_entry  (rd_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
